@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define CTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define CTF_ASSERT_IMP(lbl, ante, cons, msg) \
  `CTF_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define CTF_ASSERT_NXT(lbl, ante, cons, msg) \
  `CTF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ src/ctf_pkg.sv @@
// ---------------------------------------------------------------------------
// ctf_pkg
// shared types, constants and helpers of the tilt filter
// ---------------------------------------------------------------------------
package ctf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int ITW          = 5;

  localparam int CW   = 30;  // cordic x/y
  localparam int ZW   = 28;  // cordic angle
  localparam int AW   = 27;  // accelerometer angle, state units
  localparam int MAW  = 32;  // multiplier operand a
  localparam int MBW  = 18;  // multiplier operand b
  localparam int PW   = MAW + MBW;
  localparam int SUMW = PW + 2;
  localparam int EW   = 24;

  localparam logic signed [MBW-1:0] INV_GAIN   = MBW'(39797);
  localparam logic signed [MBW-1:0] RATE_SCALE = MBW'(120158);
  localparam logic signed [MBW-1:0] W_ONE      = MBW'(65536);
  localparam logic signed [ZW-1:0]  Z180       = ZW'(180 * 65536);
  localparam logic signed [PW-1:0]  RND_P      = PW'(32768);
  localparam logic signed [SUMW-1:0] RND_S     = SUMW'(32768);
  localparam logic signed [SUMW-1:0] EST_MAX   = SUMW'(8388607);
  localparam logic signed [SUMW-1:0] EST_MIN   = -SUMW'(8388608);
  localparam logic [15:0] BLEND_RESET = 16'd64225;

  localparam logic [2:0] CFG_ACCEL_X_OFFSET = 3'd0;
  localparam logic [2:0] CFG_ACCEL_Y_OFFSET = 3'd1;
  localparam logic [2:0] CFG_ACCEL_Z_OFFSET = 3'd2;
  localparam logic [2:0] CFG_RATE_X_OFFSET  = 3'd3;
  localparam logic [2:0] CFG_RATE_Y_OFFSET  = 3'd4;
  localparam logic [2:0] CFG_BLEND_WEIGHT   = 3'd5;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_R_INIT, OP_P_INIT, OP_ITER, OP_R_DONE, OP_P_DONE,
    OP_FIRST, OP_RATE, OP_SCALE, OP_PRED, OP_MW, OP_MA, OP_SUM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [ITW-1:0] sh;     // cordic iteration
    logic           axis;   // 0 pitch, 1 roll
    logic           first;  // result came from the accelerometer load
  } cmd_t;

  // arctangent of 2^-i in 1/65536 degree
  function automatic logic [22:0] atan_lut(input logic [ITW-1:0] i);
    logic [22:0] r;
    unique case (i)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117304;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      5'd20: r = 23'd4;
      5'd21: r = 23'd2;
      5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [EW-1:0] sat24(input logic signed [SUMW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > EST_MAX) begin
      r = EW'(EST_MAX);
    end else if (v < EST_MIN) begin
      r = EW'(EST_MIN);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

endpackage

@@ src/ctf_if.sv @@
// ---------------------------------------------------------------------------
// ctf channel interfaces
// sample input, angle output and register write channels
// ---------------------------------------------------------------------------
interface ctf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic [11:0]        elapsed_ms;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_ms,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_ms,
                output ready);
endinterface

interface ctf_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_angle;
  logic signed [14:0] roll_angle;
  logic               first_sample;
  modport source (output valid, pitch_angle, roll_angle, first_sample, input ready);
  modport sink (input valid, pitch_angle, roll_angle, first_sample, output ready);
endinterface

interface ctf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/ctf_ctrl.sv @@
// ---------------------------------------------------------------------------
// ctf_ctrl
// sequencer issuing one datapath command per cycle
// ---------------------------------------------------------------------------
module ctf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ctf_pkg::cmd_t cmd
);
  import ctf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_R_INIT, S_R_ITER, S_R_DONE, S_P_INIT, S_P_ITER, S_P_DONE,
    S_FIRST, S_RATE, S_SCALE, S_PRED, S_MW, S_MA, S_SUM, S_OUT
  } state_t;

  state_t         state_r;
  logic [ITW-1:0] it_r;
  logic           axis_r;
  logic           primed_r;
  logic           loaded_r;
  logic           out_valid_r;
  logic           in_fire;
  logic           out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.sh    = it_r;
    cmd.axis  = axis_r;
    cmd.first = loaded_r;
    unique case (state_r)
      S_IDLE:   cmd.op = in_fire ? OP_LOAD : OP_IDLE;
      S_R_INIT: cmd.op = OP_R_INIT;
      S_P_INIT: cmd.op = OP_P_INIT;
      S_R_ITER, S_P_ITER: cmd.op = OP_ITER;
      S_R_DONE: cmd.op = OP_R_DONE;
      S_P_DONE: cmd.op = OP_P_DONE;
      S_FIRST:  cmd.op = OP_FIRST;
      S_RATE:   cmd.op = OP_RATE;
      S_SCALE:  cmd.op = OP_SCALE;
      S_PRED:   cmd.op = OP_PRED;
      S_MW:     cmd.op = OP_MW;
      S_MA:     cmd.op = OP_MA;
      S_SUM:    cmd.op = OP_SUM;
      S_OUT:    cmd.op = out_free ? OP_OUT : OP_IDLE;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      it_r        <= '0;
      axis_r      <= 1'b0;
      primed_r    <= 1'b0;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_R_INIT;
          end
        end
        S_R_INIT: begin
          it_r    <= '0;
          state_r <= S_R_ITER;
        end
        S_R_ITER: begin
          it_r <= it_r + 1'b1;
          if (it_r == ITW'(NSTEPS - 1)) begin
            state_r <= S_R_DONE;
          end
        end
        S_R_DONE: state_r <= S_P_INIT;
        S_P_INIT: begin
          it_r    <= '0;
          state_r <= S_P_ITER;
        end
        S_P_ITER: begin
          it_r <= it_r + 1'b1;
          if (it_r == ITW'(NSTEPS - 1)) begin
            state_r <= S_P_DONE;
          end
        end
        S_P_DONE: begin
          axis_r   <= 1'b0;
          loaded_r <= !primed_r;
          state_r  <= primed_r ? S_RATE : S_FIRST;
        end
        S_FIRST: begin
          primed_r <= 1'b1;
          state_r  <= S_OUT;
        end
        S_RATE:  state_r <= S_SCALE;
        S_SCALE: state_r <= S_PRED;
        S_PRED:  state_r <= S_MW;
        S_MW:    state_r <= S_MA;
        S_MA:    state_r <= S_SUM;
        S_SUM: begin
          if (!axis_r) begin
            axis_r  <= 1'b1;
            state_r <= S_RATE;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/ctf_datapath.sv @@
// ---------------------------------------------------------------------------
// ctf_datapath
// bias registers, shared cordic, shared multiplier and filter state
// ---------------------------------------------------------------------------
module ctf_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ctf_pkg::cmd_t      cmd,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic [11:0]        in_elapsed_ms,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [14:0] out_roll_angle,
  output logic               out_first_sample
);
  import ctf_pkg::*;

  logic signed [15:0] ax_off_r, ay_off_r, az_off_r, gx_off_r, gy_off_r;
  logic [15:0]        w_r;

  logic signed [16:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic [11:0]        ms_r;

  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic                 czero_r;
  logic signed [AW-1:0] pitch_acc_r, roll_acc_r;

  logic signed [PW-1:0]   prod_r;
  logic signed [MAW-1:0]  pred_r;
  logic signed [SUMW-1:0] sum_r;
  logic signed [EW-1:0]   est_p_r, est_r_r;

  logic signed [14:0] pitch_out_r, roll_out_r;
  logic               first_out_r;

  // multiplier operands
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_c;
  logic signed [MBW-1:0] w_s;
  logic signed [16:0]    g_sel;
  logic signed [EW-1:0]  est_sel;
  logic signed [AW-1:0]  acc_sel;

  // cordic
  logic signed [CW-1:0] ix, iy, xs, ys;
  logic signed [PW-1:0] mag_c;
  logic signed [ZW-1:0] zval, zstep;
  logic signed [AW-1:0] acc_c;

  assign w_s     = MBW'({1'b0, w_r});
  assign g_sel   = cmd.axis ? gx_r : gy_r;
  assign est_sel = cmd.axis ? est_r_r : est_p_r;
  assign acc_sel = cmd.axis ? roll_acc_r : pitch_acc_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_R_DONE: begin
        mul_a = MAW'(cx_r);
        mul_b = INV_GAIN;
      end
      OP_RATE: begin
        mul_a = MAW'(g_sel);
        mul_b = MBW'({1'b0, ms_r});
      end
      OP_SCALE: begin
        mul_a = prod_r[MAW-1:0];
        mul_b = RATE_SCALE;
      end
      OP_MW: begin
        mul_a = pred_r;
        mul_b = w_s;
      end
      OP_MA: begin
        mul_a = MAW'(acc_sel);
        mul_b = W_ONE - w_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // vector entering the cordic: roll uses (z, y), pitch uses (|yz|, -x)
  assign mag_c = (prod_r + RND_P) >>> 16;
  always_comb begin
    if (cmd.op == OP_P_INIT) begin
      ix = mag_c[CW-1:0];
      iy = -(CW'(ax_r) <<< 8);
    end else begin
      ix = CW'(az_r) <<< 8;
      iy = CW'(ay_r) <<< 8;
    end
  end

  assign xs    = cx_r >>> cmd.sh;
  assign ys    = cy_r >>> cmd.sh;
  assign zstep = ZW'({1'b0, atan_lut(cmd.sh)});
  assign zval  = czero_r ? '0 : cz_r;
  assign acc_c = AW'((zval + ZW'(1)) >>> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_off_r <= '0;
      ay_off_r <= '0;
      az_off_r <= '0;
      gx_off_r <= '0;
      gy_off_r <= '0;
      w_r      <= BLEND_RESET;
      est_p_r  <= '0;
      est_r_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACCEL_X_OFFSET: ax_off_r <= cfg_data;
          CFG_ACCEL_Y_OFFSET: ay_off_r <= cfg_data;
          CFG_ACCEL_Z_OFFSET: az_off_r <= cfg_data;
          CFG_RATE_X_OFFSET:  gx_off_r <= cfg_data;
          CFG_RATE_Y_OFFSET:  gy_off_r <= cfg_data;
          CFG_BLEND_WEIGHT:   w_r      <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_FIRST: begin
          est_p_r <= sat24(SUMW'(pitch_acc_r));
          est_r_r <= sat24(SUMW'(roll_acc_r));
        end
        OP_SUM: begin
          if (cmd.axis) begin
            est_r_r <= sat24(sum_r >>> 16);
          end else begin
            est_p_r <= sat24(sum_r >>> 16);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ax_r <= 17'(in_accel_x) - 17'(ax_off_r);
        ay_r <= 17'(in_accel_y) - 17'(ay_off_r);
        az_r <= 17'(in_accel_z) - 17'(az_off_r);
        gx_r <= 17'(in_rate_x) - 17'(gx_off_r);
        gy_r <= 17'(in_rate_y) - 17'(gy_off_r);
        ms_r <= in_elapsed_ms;
      end
      OP_R_INIT, OP_P_INIT: begin
        czero_r <= (ix == '0) && (iy == '0);
        if (ix < 0) begin
          cx_r <= -ix;
          cy_r <= -iy;
          cz_r <= (iy >= 0) ? Z180 : -Z180;
        end else begin
          cx_r <= ix;
          cy_r <= iy;
          cz_r <= '0;
        end
      end
      OP_ITER: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + zstep;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - zstep;
        end
      end
      OP_R_DONE: begin
        roll_acc_r <= acc_c;
        prod_r     <= prod_c;
      end
      OP_P_DONE: pitch_acc_r <= acc_c;
      OP_RATE, OP_SCALE: prod_r <= prod_c;
      OP_PRED: pred_r <= MAW'(est_sel) + MAW'((prod_r + RND_P) >>> 16);
      OP_MW: sum_r <= SUMW'(prod_c) + RND_S;
      OP_MA: sum_r <= sum_r + SUMW'(prod_c);
      OP_OUT: begin
        pitch_out_r <= est_p_r[EW-1:9];
        roll_out_r  <= est_r_r[EW-1:9];
        first_out_r <= cmd.first;
      end
      default: ;
    endcase
  end

  assign out_pitch_angle  = pitch_out_r;
  assign out_roll_angle   = roll_out_r;
  assign out_first_sample = first_out_r;

endmodule

@@ src/complementary_tilt_filter_top.sv @@
// ---------------------------------------------------------------------------
// complementary_tilt_filter_top
// pitch and roll from one imu sample, gyro and accelerometer blended
// ---------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_chan   in   valid/ready    accel_x/y/z, rate_x/y, elapsed_ms
// out_chan  out  valid/ready    pitch_angle, roll_angle, first_sample
// cfg_chan  in   valid/ready    index, data (ready always high)
//
// a sample runs from its input transfer through the roll and pitch passes of
// the one shared cordic, then through the shared multiplier; the output step
// registers its result and returns the sequencer to idle, where the next
// input transfer is taken
// the first sample after reset loads the estimates and skips the rate and blend steps
// synchronous active-low reset clears the sequencer, biases and estimates
// one finished result waits in the output register while the next sample is
// taken; a stalled result only holds the second one at its final step
// ---------------------------------------------------------------------------
module complementary_tilt_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  ctf_in_if.sink      in_chan,
  ctf_out_if.source   out_chan,
  ctf_cfg_if.sink     cfg_chan
);
  import ctf_pkg::*;

  cmd_t cmd;

  // register writes are never stalled
  assign cfg_chan.ready = 1'b1;

  // sequencer: owns the handshakes and walks the datapath through a sample
  ctf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // datapath: biases, cordic, multiplier, estimates and the result register
  ctf_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_accel_x       (in_chan.accel_x),
    .in_accel_y       (in_chan.accel_y),
    .in_accel_z       (in_chan.accel_z),
    .in_rate_x        (in_chan.rate_x),
    .in_rate_y        (in_chan.rate_y),
    .in_elapsed_ms    (in_chan.elapsed_ms),
    .cfg_we           (cfg_chan.valid),
    .cfg_index        (cfg_chan.index),
    .cfg_data         (cfg_chan.data),
    .out_pitch_angle  (out_chan.pitch_angle),
    .out_roll_angle   (out_chan.roll_angle),
    .out_first_sample (out_chan.first_sample)
  );

endmodule

@@ src/ctf_checker.sv @@
// ---------------------------------------------------------------------------
// ctf_checker
// port-level checks on transfer ordering and the first-sample flag
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ctf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_first_sample
);
  logic [1:0] pend_r;
  logic       seen_r;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      seen_r <= 1'b0;
    end else begin
      pend_r <= pend_r + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire) begin
        seen_r <= 1'b1;
      end
    end
  end

  `CTF_ASSERT(a_pend_bound, pend_r != 2'd3, "more than two samples in flight")
  `CTF_ASSERT_IMP(a_no_spurious, out_fire, pend_r != 2'd0, "result without a sample")
  `CTF_ASSERT_IMP(a_first_once, out_fire && out_first_sample, !seen_r, "second first_sample")
  `CTF_ASSERT_IMP(a_first_lead, out_fire && !seen_r, out_first_sample, "first result not flagged")
  `CTF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind complementary_tilt_filter_top ctf_checker u_ctf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_first_sample (out_chan.first_sample)
);

@@ dv/ctf_tb_if.sv @@
// ---------------------------------------------------------------------------
// ctf_tb_if
// carrier for the testbench-side stall control handles
// ---------------------------------------------------------------------------
// the channel interfaces themselves come from the rtl; this file only holds
// the stall control shared by the driver and monitor processes
interface ctf_stall_if;
  logic       hold_off;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
endinterface

@@ dv/complementary_tilt_filter_top_tb.sv @@
// ---------------------------------------------------------------------------
// complementary_tilt_filter_top_tb
// self-checking bench for the complementary tilt filter
// ---------------------------------------------------------------------------
// drives imu samples through the input channel, writes the bias and blend
// registers between phases, and compares every output transfer against an
// in-bench fixed-point model of the cordic and blend arithmetic or a typed answer
// ---------------------------------------------------------------------------
module complementary_tilt_filter_top_tb;
  import ctf_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy;
    logic [11:0]        ms;
  } sample_t;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic               first;
  } angles_t;

  // directed row: sample plus optional hand-typed answer
  typedef struct {
    sample_t s;
    bit      known;
    angles_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ctf_in_if    in_chan();
  ctf_out_if   out_chan();
  ctf_cfg_if   cfg_chan();
  ctf_stall_if ctl();

  complementary_tilt_filter_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  longint bias[5];
  longint alpha;
  longint pitch_est, roll_est;
  bit     primed;

  angles_t expected_angles[$];
  int      fails = 0;
  int      results_seen = 0;
  int      firsts_seen = 0;
  longint  cycles = 0;
  localparam longint CYCLE_LIMIT = 2_000_000;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp_est(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  // vectoring rotation: returns angle in 1/65536 degree, magnitude via ref
  function automatic longint vector_angle(longint y, longint x, ref longint mag);
    longint z, xs, ys;
    int     n;
    z = 0;
    n = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint fuse_angle(longint est, longint rate, longint ms, longint acc);
    longint pred;
    pred = est + floor_shift(rate * ms * 120158 + 32768, 16);
    return clamp_est(floor_shift(alpha * pred + (65536 - alpha) * acc + 32768, 16));
  endfunction

  function automatic angles_t tilt_update(sample_t s);
    longint ax, ay, az, gx, gy, mag, mag2, r_a, p_a, r_acc, p_acc;
    angles_t a;
    ax = longint'(s.ax) - bias[CFG_ACCEL_X_OFFSET];
    ay = longint'(s.ay) - bias[CFG_ACCEL_Y_OFFSET];
    az = longint'(s.az) - bias[CFG_ACCEL_Z_OFFSET];
    gx = longint'(s.gx) - bias[CFG_RATE_X_OFFSET];
    gy = longint'(s.gy) - bias[CFG_RATE_Y_OFFSET];
    r_a = vector_angle(ay * 256, az * 256, mag);
    mag = floor_shift(mag * 39797 + 32768, 16);
    p_a = vector_angle(-ax * 256, mag, mag2);
    r_acc = floor_shift(r_a + 1, 1);
    p_acc = floor_shift(p_a + 1, 1);
    a.first = !primed;
    if (!primed) begin
      pitch_est = clamp_est(p_acc);
      roll_est = clamp_est(r_acc);
      primed = 1;
    end else begin
      pitch_est = fuse_angle(pitch_est, gy, longint'(s.ms), p_acc);
      roll_est = fuse_angle(roll_est, gx, longint'(s.ms), r_acc);
    end
    a.pitch = 15'(floor_shift(pitch_est, 9));
    a.roll = 15'(floor_shift(roll_est, 9));
    return a;
  endfunction

  // cycle counter and global timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output side: random stall, long hold-off, compare each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (expected_angles.size() == 0) begin
          fails++;
          $display("%0t unexpected result pitch %0d roll %0d", $time,
                   out_chan.pitch_angle, out_chan.roll_angle);
        end else begin
          angles_t e;
          e = expected_angles.pop_front();
          if (out_chan.first_sample) firsts_seen++;
          if (e.pitch !== out_chan.pitch_angle) begin
            fails++;
            $display("%0t pitch exp %0d got %0d", $time, e.pitch, out_chan.pitch_angle);
          end
          if (e.roll !== out_chan.roll_angle) begin
            fails++;
            $display("%0t roll exp %0d got %0d", $time, e.roll, out_chan.roll_angle);
          end
          if (e.first !== out_chan.first_sample) begin
            fails++;
            $display("%0t first exp %0b got %0b", $time, e.first, out_chan.first_sample);
          end
        end
      end
      out_chan.ready <= !ctl.hold_off && ($urandom_range(99) >= ctl.snk_stall_pct);
    end
  end

  // ---- stimulus helpers ---------------------------------------------------

  // one register write on the cfg channel, model follows; valid stays high
  // for back-to-back writes and is dropped by the caller
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    if (idx < CFG_BLEND_WEIGHT) bias[idx] = longint'(signed'(val));
    else if (idx == CFG_BLEND_WEIGHT) alpha = longint'(val);
  endtask

  // offer one sample, with random idle cycles first
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < ctl.src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.accel_x <= s.ax;
    in_chan.accel_y <= s.ay;
    in_chan.accel_z <= s.az;
    in_chan.rate_x <= s.gx;
    in_chan.rate_y <= s.gy;
    in_chan.elapsed_ms <= s.ms;
    do @(posedge clk); while (!in_chan.ready);
    expected_angles.push_back(tilt_update(s));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(bit narrow);
    sample_t s;
    if (narrow) begin
      // plausible imu: gravity mostly on z, modest rates and dt
      s.ax = 16'($signed($urandom_range(8000)) - 4000);
      s.ay = 16'($signed($urandom_range(8000)) - 4000);
      s.az = 16'($signed($urandom_range(4000)) + 8000);
      s.gx = 16'($signed($urandom_range(4000)) - 2000);
      s.gy = 16'($signed($urandom_range(4000)) - 2000);
      s.ms = 12'($urandom_range(40));
    end else begin
      s.ax = 16'($urandom);
      s.ay = 16'($urandom);
      s.az = 16'($urandom);
      s.gx = 16'($urandom);
      s.gy = 16'($urandom);
      s.ms = 12'($urandom);
    end
    return s;
  endfunction

  function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int ms);
    sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.ms = 12'(ms);
    return s;
  endfunction

  // ---- main sequence ------------------------------------------------------

  row_t directed[$];
  sample_t s;
  int n_sent = 0;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.accel_x = '0; in_chan.accel_y = '0; in_chan.accel_z = '0;
    in_chan.rate_x = '0; in_chan.rate_y = '0; in_chan.elapsed_ms = '0;
    cfg_chan.valid = 1'b0; cfg_chan.index = '0; cfg_chan.data = '0;
    ctl.hold_off = 1'b0; ctl.src_idle_pct = 0; ctl.snk_stall_pct = 0;
    for (int i = 0; i < 5; i++) bias[i] = 0;
    alpha = BLEND_RESET;
    pitch_est = 0; roll_est = 0; primed = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: zero vector loads zero (typed answer), then extremes,
    // negative-x turn on both signs of y, huge rate*dt saturation
    directed.push_back('{mk(0, 0, 0, 0, 0, 0), 1, '{15'sd0, 15'sd0, 1'b1}});
    directed.push_back('{mk(0, 0, 0, 0, 0, 0), 1, '{15'sd0, 15'sd0, 1'b0}});
    directed.push_back('{mk(0, 0, 1024, 0, 0, 20), 0, '{0, 0, 0}});
    directed.push_back('{mk(0, 100, -1024, 0, 0, 20), 0, '{0, 0, 0}});
    directed.push_back('{mk(0, -100, -1024, 0, 0, 20), 0, '{0, 0, 0}});
    directed.push_back('{mk(0, 0, -1024, 0, 0, 20), 0, '{0, 0, 0}});
    directed.push_back('{mk(32767, 32767, 32767, 32767, 32767, 4095), 0, '{0, 0, 0}});
    directed.push_back('{mk(32767, 32767, 32767, 32767, 32767, 4095), 0, '{0, 0, 0}});
    directed.push_back('{mk(-32768, -32768, -32768, -32768, -32768, 4095), 0, '{0, 0, 0}});
    directed.push_back('{mk(-32768, -32768, -32768, -32768, -32768, 4095), 0, '{0, 0, 0}});
    directed.push_back('{mk(-32768, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
    directed.push_back('{mk(32767, 0, 0, 0, 0, 1), 0, '{0, 0, 0}});
    directed.push_back('{mk(0, 32767, 0, 1, -1, 1), 0, '{0, 0, 0}});
    directed.push_back('{mk(0, -32768, 0, -1, 1, 4095), 0, '{0, 0, 0}});
    directed.push_back('{mk(-1, -1, -1, -1, -1, 2048), 0, '{0, 0, 0}});
    directed.push_back('{mk(21845, -21846, 10922, 21845, -21846, 2730), 0, '{0, 0, 0}});

    foreach (directed[i]) begin
      send_sample(directed[i].s);
      if (directed[i].known) expected_angles[$] = directed[i].ans;
      n_sent++;
    end
    drain();

    // bias and blend extremes, out-of-range indexes ignored, random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_BLEND_WEIGHT, 16'hFFFF);
          write_reg(3'd6, 16'h1234);
          write_reg(3'd7, 16'h8000);
        end
        1: write_reg(CFG_BLEND_WEIGHT, 16'h0000);
        2: begin
          write_reg(CFG_ACCEL_X_OFFSET, 16'h7FFF);
          write_reg(CFG_ACCEL_Y_OFFSET, 16'h8000);
          write_reg(CFG_ACCEL_Z_OFFSET, 16'h7FFF);
          write_reg(CFG_RATE_X_OFFSET, 16'h8000);
          write_reg(CFG_RATE_Y_OFFSET, 16'h7FFF);
          write_reg(CFG_BLEND_WEIGHT, 16'd32768);
        end
        3: for (int r = 0; r < 6; r++) write_reg(3'(r), 16'($urandom));
        default: begin
          for (int r = 0; r < 5; r++) write_reg(3'(r), 16'($urandom_range(400)) - 16'd200);
          write_reg(CFG_BLEND_WEIGHT, BLEND_RESET);
        end
      endcase
      cfg_chan.valid <= 1'b0;
      ctl.src_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 53 : 0;
      ctl.snk_stall_pct = (ph % 4 == 2) ? 53 : (ph % 4 == 3) ? 21 : 0;
      if (ph % 4 == 3) ctl.src_idle_pct = 21;
      for (int k = 0; k < 220; k++) begin
        // long hold-off mid-phase so the output backs up into the input
        if (ph == 5 && k == 50) begin
          fork
            begin
              ctl.hold_off = 1'b1;
              repeat (600) @(posedge clk);
              ctl.hold_off = 1'b0;
            end
          join_none
        end
        s = rand_sample($urandom_range(99) < 80);
        send_sample(s);
        n_sent++;
      end
      drain();
    end

    $display("covered %0d samples in 8 register phases, %0d results, %0d filter loads",
             n_sent, results_seen, firsts_seen);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
